// ----- rtl/core/gct_pkg.sv -----
// ----------------------------------------------------------------------------
// Gerber command tokenizer package
// Shared types and codes: token kinds, character codes, position and token
// records passed between the tokenizer modules.
// ----------------------------------------------------------------------------
package gct_pkg;

  // Token kinds
  localparam logic [4:0] KIND_G01 = 5'd0;
  localparam logic [4:0] KIND_G02 = 5'd1;
  localparam logic [4:0] KIND_G03 = 5'd2;
  localparam logic [4:0] KIND_G04 = 5'd3;
  localparam logic [4:0] KIND_G36 = 5'd4;
  localparam logic [4:0] KIND_G37 = 5'd5;
  localparam logic [4:0] KIND_G54 = 5'd6;
  localparam logic [4:0] KIND_G55 = 5'd7;
  localparam logic [4:0] KIND_G70 = 5'd8;
  localparam logic [4:0] KIND_G71 = 5'd9;
  localparam logic [4:0] KIND_G74 = 5'd10;
  localparam logic [4:0] KIND_G75 = 5'd11;
  localparam logic [4:0] KIND_G90 = 5'd12;
  localparam logic [4:0] KIND_G91 = 5'd13;
  localparam logic [4:0] KIND_FS  = 5'd14;
  localparam logic [4:0] KIND_MO  = 5'd15;
  localparam logic [4:0] KIND_ERR = 5'd16;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;

  // Source position, each member already clamped to its output width
  typedef struct packed {
    logic [31:0] offset;
    logic [23:0] line;
    logic [15:0] column;
  } pos_t;

  // One byte moving into the parser and position tracker
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } step_t;

  // One result token
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] comment_len;
    logic        zeros;
    logic        notation;
    logic [3:0]  x_int;
    logic [3:0]  x_dec;
    logic [3:0]  y_int;
    logic [3:0]  y_dec;
    logic        unit_mm;
    pos_t        pos;
  } token_t;

endpackage

// ----- rtl/core/gct_pos_track.sv -----
// ----------------------------------------------------------------------------
// Gerber tokenizer position tracker
// Saturating byte offset, line and column counters for the source text.
// ----------------------------------------------------------------------------
module gct_pos_track import gct_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  step_t step_i,
  input  logic  halt_i,
  output pos_t  pos_o
);

  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [23:0]            line_q, line_d;
  logic [15:0]            column_q, column_d;
  logic [63:0]            offset_wide;

  always_comb begin
    offset_d = offset_q;
    line_d   = line_q;
    column_d = column_q;
    if (step_i.valid && !halt_i) begin
      if (offset_q != '1) offset_d = offset_q + 1'b1;
      if (step_i.data == CH_LF) begin
        if (line_q != '1) line_d = line_q + 1'b1;
        column_d = '0;
      end else if (column_q != '1) begin
        column_d = column_q + 1'b1;
      end
    end
    // end of file: start over
    if (step_i.valid && step_i.last) begin
      offset_d = '0;
      line_d   = '0;
      column_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      line_q   <= '0;
      column_q <= '0;
    end else begin
      offset_q <= offset_d;
      line_q   <= line_d;
      column_q <= column_d;
    end
  end

  assign offset_wide   = 64'(offset_q);
  assign pos_o.offset  = (offset_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                 : offset_wide[31:0];
  assign pos_o.line    = line_q;
  assign pos_o.column  = column_q;

endmodule

// ----- rtl/core/gct_parser.sv -----
// ----------------------------------------------------------------------------
// Gerber tokenizer command parser
// Per-byte state machine that recognizes G-codes, G04 comments, %FS and %MO,
// and forms one token per complete command or syntax error.
// ----------------------------------------------------------------------------
module gct_parser import gct_pkg::*; #(
  parameter int COMMENT_COUNT_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  step_t  step_i,
  input  pos_t   pos_i,
  output logic   halt_o,
  output logic   tok_valid_o,
  output token_t tok_o
);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_GZERO    = 5'd1;
  localparam logic [4:0] PH_GDIG     = 5'd2;
  localparam logic [4:0] PH_GDIG4    = 5'd3;
  localparam logic [4:0] PH_GCOMMENT = 5'd4;
  localparam logic [4:0] PH_PCT      = 5'd5;
  localparam logic [4:0] PH_FS_S     = 5'd7;
  localparam logic [4:0] PH_FS_Z     = 5'd8;
  localparam logic [4:0] PH_FS_N     = 5'd9;
  localparam logic [4:0] PH_FS_X     = 5'd10;
  localparam logic [4:0] PH_FS_XI    = 5'd11;
  localparam logic [4:0] PH_FS_XD    = 5'd12;
  localparam logic [4:0] PH_FS_Y     = 5'd13;
  localparam logic [4:0] PH_FS_YI    = 5'd14;
  localparam logic [4:0] PH_FS_YD    = 5'd15;
  localparam logic [4:0] PH_FS_STAR  = 5'd16;
  localparam logic [4:0] PH_FS_END   = 5'd17;
  localparam logic [4:0] PH_MO_O     = 5'd19;
  localparam logic [4:0] PH_MO_U     = 5'd20;
  localparam logic [4:0] PH_MO_V     = 5'd21;
  localparam logic [4:0] PH_MO_STAR  = 5'd22;
  localparam logic [4:0] PH_MO_END   = 5'd23;

  function automatic logic [4:0] code_kind(input logic [6:0] c);
    case (c)
      7'd1:    return KIND_G01;
      7'd2:    return KIND_G02;
      7'd3:    return KIND_G03;
      7'd4:    return KIND_G04;
      7'd36:   return KIND_G36;
      7'd37:   return KIND_G37;
      7'd54:   return KIND_G54;
      7'd55:   return KIND_G55;
      7'd70:   return KIND_G70;
      7'd71:   return KIND_G71;
      7'd74:   return KIND_G74;
      7'd75:   return KIND_G75;
      7'd90:   return KIND_G90;
      7'd91:   return KIND_G91;
      default: return KIND_ERR;
    endcase
  endfunction

  logic [4:0]                    phase_q, phase_d;
  logic [6:0]                    code_q, code_d;
  logic                          big_q, big_d;
  logic [COMMENT_COUNT_BITS-1:0] cmt_q, cmt_d, cmt_inc;
  logic                          zeros_q, zeros_d;
  logic                          nota_q, nota_d;
  logic                          mm_q, mm_d;
  logic [15:0]                   nib_q, nib_d;
  pos_t                          start_q, start_d;
  logic                          halt_q, halt_d;

  logic [7:0]  b;
  logic        dig;
  logic [3:0]  d;
  logic [9:0]  code_x10;
  logic [4:0]  kind_lut;
  logic        known;
  logic        emit;
  logic        fail;
  logic [4:0]  kind_sel;
  logic [31:0] cmt_wide;
  logic [15:0] cmt_clamp;
  logic [15:0] cmt_sel;
  token_t      tok;

  assign b        = step_i.data;
  assign dig      = (b >= CH_ZERO) && (b <= CH_NINE);
  assign d        = 4'(b - CH_ZERO);
  assign code_x10 = 10'({code_q, 3'b000}) + 10'({code_q, 1'b0}) + 10'(d);
  assign kind_lut = code_kind(code_q);
  assign known    = !big_q && (kind_lut != KIND_ERR);
  assign cmt_inc  = (cmt_q == '1) ? cmt_q : cmt_q + 1'b1;
  assign cmt_wide = 32'(cmt_q);
  assign cmt_clamp = (cmt_wide > 32'h0000_FFFF) ? 16'hFFFF : cmt_wide[15:0];

  always_comb begin
    phase_d  = phase_q;
    code_d   = code_q;
    big_d    = big_q;
    cmt_d    = cmt_q;
    zeros_d  = zeros_q;
    nota_d   = nota_q;
    mm_d     = mm_q;
    nib_d    = nib_q;
    start_d  = start_q;
    halt_d   = halt_q;
    emit     = 1'b0;
    fail     = 1'b0;
    kind_sel = KIND_ERR;
    cmt_sel  = '0;

    if (step_i.valid && !halt_q) begin
      case (phase_q)
        PH_IDLE: begin
          if (b != CH_SPACE && b != CH_CR && b != CH_LF) begin
            start_d = pos_i;
            code_d  = '0;
            big_d   = 1'b0;
            cmt_d   = '0;
            zeros_d = 1'b0;
            nota_d  = 1'b0;
            mm_d    = 1'b0;
            nib_d   = '0;
            if (b == CH_G) phase_d = PH_GZERO;
            else if (b == CH_PCT) phase_d = PH_PCT;
            else fail = 1'b1;
          end
        end
        PH_GZERO: begin
          if (b == CH_ZERO) begin
          end else if (dig) begin
            code_d  = 7'(d);
            phase_d = (b == CH_FOUR) ? PH_GDIG4 : PH_GDIG;
          end else begin
            fail = 1'b1;
          end
        end
        PH_GDIG, PH_GDIG4: begin
          if (dig) begin
            if (!big_q) begin
              if (code_x10 > 10'd99) big_d = 1'b1;
              else code_d = code_x10[6:0];
            end
            if (phase_q == PH_GDIG4) cmt_d = cmt_inc;
          end else if (b == CH_STAR) begin
            if (known) begin
              emit     = 1'b1;
              kind_sel = kind_lut;
              phase_d  = PH_IDLE;
            end else if (phase_q == PH_GDIG4 && cmt_q != '0) begin
              emit     = 1'b1;
              kind_sel = KIND_G04;
              cmt_sel  = cmt_clamp;
              phase_d  = PH_IDLE;
            end else begin
              fail = 1'b1;
            end
          end else if (phase_q == PH_GDIG4 && b != CH_PCT) begin
            cmt_d   = cmt_inc;
            phase_d = PH_GCOMMENT;
          end else begin
            fail = 1'b1;
          end
        end
        PH_GCOMMENT: begin
          if (b == CH_STAR) begin
            emit     = 1'b1;
            kind_sel = KIND_G04;
            cmt_sel  = cmt_clamp;
            phase_d  = PH_IDLE;
          end else if (b == CH_PCT) begin
            fail = 1'b1;
          end else begin
            cmt_d = cmt_inc;
          end
        end
        PH_PCT: begin
          if (b == CH_F) phase_d = PH_FS_S;
          else if (b == CH_M) phase_d = PH_MO_O;
          else fail = 1'b1;
        end
        PH_FS_S, PH_FS_X, PH_FS_Y, PH_FS_STAR, PH_MO_O, PH_MO_STAR: begin
          // fixed letter of the command shape
          case (phase_q)
            PH_FS_S:    fail = (b != CH_S);
            PH_FS_X:    fail = (b != CH_X);
            PH_FS_Y:    fail = (b != CH_Y);
            PH_MO_O:    fail = (b != CH_O);
            default:    fail = (b != CH_STAR);
          endcase
          if (!fail) phase_d = phase_q + 5'd1;
        end
        PH_FS_Z: begin
          if (b == CH_T) zeros_d = 1'b1;
          if (b == CH_T || b == CH_L) phase_d = PH_FS_N;
          else fail = 1'b1;
        end
        PH_FS_N: begin
          if (b == CH_I) nota_d = 1'b1;
          if (b == CH_I || b == CH_A) phase_d = PH_FS_X;
          else fail = 1'b1;
        end
        PH_FS_XI, PH_FS_XD, PH_FS_YI, PH_FS_YD: begin
          if (dig) begin
            nib_d   = {nib_q[11:0], d};
            phase_d = phase_q + 5'd1;
          end else begin
            fail = 1'b1;
          end
        end
        PH_FS_END, PH_MO_END: begin
          if (b == CH_PCT) begin
            emit     = 1'b1;
            kind_sel = (phase_q == PH_FS_END) ? KIND_FS : KIND_MO;
            phase_d  = PH_IDLE;
          end else begin
            fail = 1'b1;
          end
        end
        PH_MO_U: begin
          if (b == CH_M) mm_d = 1'b1;
          if (b == CH_M || b == CH_I) phase_d = PH_MO_V;
          else fail = 1'b1;
        end
        PH_MO_V: begin
          if (b == (mm_q ? CH_M : CH_N)) phase_d = PH_MO_STAR;
          else fail = 1'b1;
        end
        default: fail = 1'b1;
      endcase

      // file cut off inside a command
      if (step_i.last && !emit && !fail && phase_d != PH_IDLE) fail = 1'b1;

      if (fail) begin
        emit     = 1'b0;
        kind_sel = KIND_ERR;
        cmt_sel  = '0;
        halt_d   = 1'b1;
        phase_d  = PH_IDLE;
      end
    end

    tok = '0;
    tok.kind        = kind_sel;
    tok.comment_len = cmt_sel;
    if (kind_sel == KIND_FS) begin
      tok.zeros    = zeros_q;
      tok.notation = nota_q;
      tok.x_int    = nib_q[15:12];
      tok.x_dec    = nib_q[11:8];
      tok.y_int    = nib_q[7:4];
      tok.y_dec    = nib_q[3:0];
    end
    if (kind_sel == KIND_MO) tok.unit_mm = mm_q;
    tok.pos = start_d;

    // end of file: back to the reset state, error halt included
    if (step_i.valid && step_i.last) begin
      phase_d = PH_IDLE;
      code_d  = '0;
      big_d   = 1'b0;
      cmt_d   = '0;
      zeros_d = 1'b0;
      nota_d  = 1'b0;
      mm_d    = 1'b0;
      nib_d   = '0;
      start_d = '0;
      halt_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      code_q  <= '0;
      big_q   <= 1'b0;
      cmt_q   <= '0;
      zeros_q <= 1'b0;
      nota_q  <= 1'b0;
      mm_q    <= 1'b0;
      nib_q   <= '0;
      start_q <= '0;
      halt_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      code_q  <= code_d;
      big_q   <= big_d;
      cmt_q   <= cmt_d;
      zeros_q <= zeros_d;
      nota_q  <= nota_d;
      mm_q    <= mm_d;
      nib_q   <= nib_d;
      start_q <= start_d;
      halt_q  <= halt_d;
    end
  end

  assign halt_o      = halt_q;
  assign tok_valid_o = emit || fail;
  assign tok_o       = tok;

endmodule

// ----- rtl/core/gerber_command_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// Gerber command tokenizer, top level
// Streams Gerber text bytes in and delivers one token per recognized command
// or syntax error.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry data_byte_i and last_byte_i,
//   one source byte per transaction. Set last_byte_i on the final byte of a
//   file; afterwards the tokenizer starts over with counters at zero.
//   Output channel: out_valid_o / out_stall_i carry one token per transaction.
//   Bytes that end no command (whitespace, middle of a command) give no token.
// Timing:
//   A byte is held in the input register, then the parser updates its
//   state and writes the result register, which then shows the token.
//   Throughput is one byte per cycle while no token is held under
//   out_stall_i.
// Stall:
//   While a token waits under out_stall_i the input register keeps its byte
//   and in_stall_o rises only once that byte is ready to be parsed.
// Reset:
//   rst_ni clears the valid flags of both registers, the parser state and the position counters.
// ----------------------------------------------------------------------------
module gerber_command_tokenizer_top import gct_pkg::*; #(
  parameter int OFFSET_BITS        = 32,
  parameter int COMMENT_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] comment_length_o,
  output logic        zeros_mode_o,
  output logic        coord_notation_o,
  output logic [3:0]  x_integer_digits_o,
  output logic [3:0]  x_decimal_digits_o,
  output logic [3:0]  y_integer_digits_o,
  output logic [3:0]  y_decimal_digits_o,
  output logic        unit_millimetres_o,
  output logic [31:0] start_offset_o,
  output logic [23:0] start_line_o,
  output logic [15:0] start_column_o
);

  // Input register
  logic       in_vld_q;
  logic [7:0] in_data_q;
  logic       in_last_q;

  // Result register
  logic   out_vld_q;
  token_t out_tok_q;

  logic   res_ready;
  logic   fire;
  logic   accept;
  step_t  step;
  pos_t   pos;
  logic   halt;
  logic   tok_valid;
  token_t tok;

  // The result register frees up when empty or when its token is taken.
  assign res_ready  = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && res_ready;
  assign in_stall_o = in_vld_q && !res_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // Hold the byte until the parser consumes it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  assign step.valid = fire;
  assign step.data  = in_data_q;
  assign step.last  = in_last_q;

  gct_pos_track #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .halt_i (halt),
    .pos_o  (pos)
  );

  gct_parser #(
    .COMMENT_COUNT_BITS(COMMENT_COUNT_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pos_i       (pos),
    .halt_o      (halt),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  // Advance the result register whenever it is free; drop bytes with no token.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= fire && tok_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && tok_valid) begin
      out_tok_q <= tok;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign token_kind_o       = out_tok_q.kind;
  assign comment_length_o   = out_tok_q.comment_len;
  assign zeros_mode_o       = out_tok_q.zeros;
  assign coord_notation_o   = out_tok_q.notation;
  assign x_integer_digits_o = out_tok_q.x_int;
  assign x_decimal_digits_o = out_tok_q.x_dec;
  assign y_integer_digits_o = out_tok_q.y_int;
  assign y_decimal_digits_o = out_tok_q.y_dec;
  assign unit_millimetres_o = out_tok_q.unit_mm;
  assign start_offset_o     = out_tok_q.pos.offset;
  assign start_line_o       = out_tok_q.pos.line;
  assign start_column_o     = out_tok_q.pos.column;

  // Input backpressure only comes from a blocked result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (token_kind_o <= KIND_ERR))
    else $error("token kind out of range");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o == KIND_ERR) |->
      (comment_length_o == 16'd0 && zeros_mode_o == 1'b0 &&
       unit_millimetres_o == 1'b0 && x_integer_digits_o == 4'd0))
    else $error("error token carries command fields");

  a_cmt_only_g04: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o != KIND_G04) |-> (comment_length_o == 16'd0))
    else $error("comment length on a token other than G04");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled token lost");

endmodule
